>>> hw/rtl/fixed_slot_free_list_allocator_defines.svh
// Assertion macros shared by the allocator checker
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define FSL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define FSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fsl_pkg.sv
// Types, codes and constants of the fixed-slot free-list allocator
`timescale 1ns / 1ps

package fsl_pkg;

	localparam int NUM_SLOTS = 256;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int LINK_W    = IDX_W + 1;
	localparam int COUNT_W   = 9;
	localparam int BYTES_W   = 13;
	localparam int OFF_W     = 20;
	localparam int PROD_W    = IDX_W + BYTES_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [LINK_W-1:0]  END_LINK       = LINK_W'(NUM_SLOTS);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
	localparam logic [BYTES_W-1:0] MIN_SLOT_BYTES = BYTES_W'(8);

	// Request command codes
	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	// Response status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_NULL  = 2'd2;
	localparam logic [1:0] STS_BAD   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = CFG_IDX_W'(1);

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] slot_index;
		logic       null_pointer;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         granted_slot;
		logic [OFF_W-1:0]   byte_offset;
		logic [COUNT_W-1:0] live_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_ALLOC
	} state_t;

endpackage

>>> hw/rtl/fixed_slot_free_list_allocator.sv
// Fixed-slot free-list allocator top level
//
// Keeps a pool of equal-size slots as a singly linked free list in a link RAM
// with registered read data. A request is taken only while the block is
// idle and its response register is free or draining. Free, a free of a null
// pointer, allocate on an empty list and the unused command are answered from
// the idle state; allocate passes through ALLOC, since the head's link comes
// back from the link RAM in the cycle after its read; init walks the slots in
// INIT, one link RAM write per slot. The list is empty after reset, so
// allocate reports no free slot until an init or a free has run; the link RAM
// has no clearing pass. Configuration writes are always ready.
`timescale 1ns / 1ps

module fixed_slot_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  fsl_pkg::req_t                  req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output fsl_pkg::rsp_t                  rsp_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsl_pkg::BYTES_W-1:0]    cfg_data
);

	import fsl_pkg::*;

	state_t             state_q, state_d;
	logic [LINK_W-1:0]  head_q, head_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [LINK_W-1:0]  walk_q, walk_d;
	logic [LINK_W-1:0]  walk_next;
	logic [COUNT_W-1:0] slot_count_q;
	logic [BYTES_W-1:0] slot_bytes_q;
	logic [COUNT_W-1:0] init_n;
	logic [BYTES_W-1:0] slot_size;
	logic [PROD_W-1:0]  offset_prod;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_load;
	logic               req_acc;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	logic [LINK_W-1:0]  mem_wdata;
	logic [LINK_W-1:0]  mem_rdata;

	// Link RAM: next-slot link of every free slot
	fsl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(NUM_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Take a request only when idle and the response register can load
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	// Clamp slot count and slot size
	assign init_n      = (slot_count_q > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
		: slot_count_q;
	assign slot_size   = (slot_bytes_q < MIN_SLOT_BYTES) ? MIN_SLOT_BYTES : slot_bytes_q;
	assign offset_prod = PROD_W'(head_q[IDX_W-1:0]) * PROD_W'(slot_size);
	assign walk_next   = walk_q + LINK_W'(1);

	// Next state, list update and response
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		walk_d    = walk_q;
		mem_we    = 1'b0;
		mem_addr  = head_q[IDX_W-1:0];
		mem_wdata = END_LINK;
		rsp_load  = 1'b0;
		rsp_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (req_data.command)
						CMD_INIT: begin
							if (init_n == '0) begin
								head_d   = END_LINK;
								rsp_load = 1'b1;
							end else begin
								walk_d  = '0;
								state_d = ST_INIT;
							end
						end
						CMD_ALLOC: begin
							if (head_q == END_LINK) begin
								rsp_d.status = STS_EMPTY;
								rsp_load     = 1'b1;
							end else begin
								state_d = ST_ALLOC;
							end
						end
						CMD_FREE: begin
							if (req_data.null_pointer) begin
								rsp_d.status = STS_NULL;
							end else begin
								mem_we    = 1'b1;
								mem_addr  = req_data.slot_index;
								mem_wdata = head_q;
								head_d    = {1'b0, req_data.slot_index};
								if (count_q != '0) begin
									count_d = count_q - COUNT_W'(1);
								end
							end
							rsp_load = 1'b1;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			ST_INIT: begin
				// Link one slot per cycle, terminate the last one
				mem_we   = 1'b1;
				mem_addr = walk_q[IDX_W-1:0];
				walk_d   = walk_next;
				if (COUNT_W'(walk_next) == init_n) begin
					mem_wdata = END_LINK;
					head_d    = '0;
					rsp_load  = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					mem_wdata = walk_next;
				end
			end
			ST_ALLOC: begin
				// Pop the head using the link read last cycle
				head_d = mem_rdata;
				if (count_q != COUNT_MAX) begin
					count_d = count_q + COUNT_W'(1);
				end
				rsp_d.granted_slot = head_q[IDX_W-1:0];
				rsp_d.byte_offset  = offset_prod[OFF_W-1:0];
				rsp_load           = 1'b1;
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		rsp_d.live_count = count_d;
	end

	// State register and list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= END_LINK;
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			walk_q  <= walk_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= COUNT_W'(256);
			slot_bytes_q <= BYTES_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLOT_COUNT: slot_count_q <= cfg_data[COUNT_W-1:0];
				CFG_SLOT_BYTES: slot_bytes_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Response valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

>>> hw/rtl/fsl_ram.sv
// Generic single-port RAM with registered read data
`timescale 1ns / 1ps

module fsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on enable, register the read of the addressed entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fsl_checker.sv
// Port-level checker for the allocator and its bind
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_defines.svh"

module fsl_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  fsl_pkg::req_t                  req_data,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  fsl_pkg::rsp_t                  rsp_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [fsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsl_pkg::BYTES_W-1:0]    cfg_data
);

	import fsl_pkg::*;

	// Hold a stalled response
	`FSL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

	// Never report the unused status code
	`FSL_ASSERT_SAME(a_status_legal, rsp_valid, rsp_data.status != STS_BAD, "illegal status code")

	// Grant nothing on a failed request
	`FSL_ASSERT_SAME(a_fail_no_grant, rsp_valid && rsp_data.status != STS_OK, rsp_data.granted_slot == 8'd0 && rsp_data.byte_offset == '0, "failed request carries a grant")

	// A nonzero offset belongs to a nonzero slot
	`FSL_ASSERT_SAME(a_offset_slot, rsp_valid && rsp_data.byte_offset != '0, rsp_data.granted_slot != 8'd0, "offset without slot")

endmodule

bind fixed_slot_free_list_allocator fsl_checker u_fsl_checker (.*);
